// ===== rtl/cma_pkg.sv =====
// Shared constants and state types for the centered moving average block.
// No dependencies; imported by every module of the block except cma_queue.
package cma_pkg;

  localparam int MAX_HALF_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int HW_W       = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0]      REG_HALF_WINDOW = 1'b0;
  localparam logic [HW_W-1:0] HW_RESET        = 5'd1;

  typedef enum logic {
    F_IDLE,
    F_EMIT
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ===== rtl/cma_queue.sv =====
// Small register FIFO carrying result jobs from the front to the back.
// Depends on nothing beyond its parameters.
module cma_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/cma_front.sv =====
// Front end: accepts samples, writes the window ring, tracks frame position
// counts and issues one job (ring start, sample count, last) per result.
// Depends on cma_pkg.
module cma_front #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF,
  localparam int RING_DEPTH = 2 * MAX_HALF + 1,
  localparam int IDX_W      = $clog2(RING_DEPTH),
  localparam int CNT_W      = $clog2(RING_DEPTH + 1),
  localparam int JOB_W      = IDX_W + CNT_W + 1,
  localparam int WR_W       = 1 + IDX_W + SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_frame_end,
  input  logic [cma_pkg::HW_W-1:0]      half_window,
  input  logic                          q_empty,
  input  logic                          q_full,
  input  logic                          back_busy,
  output logic                          job_push,
  output logic [JOB_W-1:0]              job_data,
  output logic [WR_W-1:0]               ring_wr
);
  import cma_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic             last;
  } job_t;

  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       addr;
    logic [SAMPLE_BITS-1:0] data;
  } ring_wr_t;

  front_state_t     state_r, state_nxt;
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] rcv_r, rcv_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic             end_r, end_nxt;
  logic             accept;
  job_t             job;
  ring_wr_t         wr;

  logic [CNT_W-1:0] hw_c, avail, pm1, left, right, offset;
  logic [IDX_W-1:0] newest;
  logic [CNT_W:0]   wrapped;
  logic             want;

  assign in_ready = (state_r == F_IDLE) && q_empty && !back_busy;
  assign accept   = in_valid && in_ready;

  assign wr.en    = accept;
  assign wr.addr  = wr_ptr_r;
  assign wr.data  = in_sample;
  assign ring_wr  = wr;
  assign job_data = job;

  always_comb begin
    hw_c    = CNT_W'(half_window);
    avail   = rcv_r - pend_r;
    pm1     = pend_r - 1'b1;
    left    = (avail < hw_c) ? avail : hw_c;
    right   = (pm1 < hw_c) ? pm1 : hw_c;
    offset  = pm1 + left;
    newest  = (wr_ptr_r == '0) ? IDX_W'(RING_DEPTH - 1) : wr_ptr_r - 1'b1;
    wrapped = (CNT_W + 1)'(newest) + (CNT_W + 1)'(RING_DEPTH) - {1'b0, offset};
    want    = end_r ? (pend_r != '0) : (pend_r > hw_c);

    job.count = left + right + 1'b1;
    job.last  = end_r && (pend_r == CNT_W'(1));
    if (CNT_W'(newest) >= offset) begin
      job.start = newest - IDX_W'(offset);
    end else begin
      job.start = IDX_W'(wrapped);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rcv_nxt    = rcv_r;
    pend_nxt   = pend_r;
    end_nxt    = end_r;
    job_push   = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          wr_ptr_nxt = (wr_ptr_r == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
          if (rcv_r != CNT_W'(RING_DEPTH)) begin
            rcv_nxt = rcv_r + 1'b1;
          end
          if (pend_r != CNT_W'(RING_DEPTH)) begin
            pend_nxt = pend_r + 1'b1;
          end
          end_nxt   = in_frame_end;
          state_nxt = F_EMIT;
        end
      end
      F_EMIT: begin
        if (want) begin
          if (!q_full) begin
            job_push = 1'b1;
            pend_nxt = pend_r - 1'b1;
          end
        end else begin
          if (end_r) begin
            rcv_nxt  = '0;
            pend_nxt = '0;
          end
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      wr_ptr_r <= '0;
      rcv_r    <= '0;
      pend_r   <= '0;
      end_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rcv_r    <= rcv_nxt;
      pend_r   <= pend_nxt;
      end_r    <= end_nxt;
    end
  end

endmodule

// ===== rtl/cma_back.sv =====
// Back end: holds the window ring memory, sums each job's samples one per
// cycle, divides by the count with a restoring divider, registers the result.
// Depends on cma_pkg.
module cma_back #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF,
  localparam int RING_DEPTH = 2 * MAX_HALF + 1,
  localparam int IDX_W      = $clog2(RING_DEPTH),
  localparam int CNT_W      = $clog2(RING_DEPTH + 1),
  localparam int JOB_W      = IDX_W + CNT_W + 1,
  localparam int WR_W       = 1 + IDX_W + SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [WR_W-1:0]               ring_wr,
  input  logic                          q_empty,
  output logic                          job_pop,
  input  logic [JOB_W-1:0]              job_data,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_last
);
  import cma_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic             last;
  } job_t;

  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       addr;
    logic [SAMPLE_BITS-1:0] data;
  } ring_wr_t;

  job_t     job;
  ring_wr_t wr;

  assign job = job_data;
  assign wr  = ring_wr;

  logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

  back_state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]              rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0]              issue_r, issue_nxt;
  logic                          dv_r, dv_nxt;
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]              div_r, div_nxt;
  logic                          last_r, last_nxt;
  logic [SUM_W-1:0]              dq_r, dq_nxt;
  logic [CNT_W-1:0]              rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_average_r, out_average_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [CNT_W:0]   rem_sh, rem_diff;
  logic             ge;
  logic [SUM_W-1:0] quot;

  assign busy        = (state_r == B_READ);
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;
  assign out_last    = out_last_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ring_mem[wr.addr] <= wr.data;
    end
    rd_data_r <= ring_mem[rd_addr_r];
  end

  always_comb begin
    rem_sh   = {rem_r, dq_r[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, div_r};
    ge       = (rem_sh >= {1'b0, div_r});
    quot     = neg_r ? (~dq_r + 1'b1) : dq_r;
  end

  always_comb begin
    state_nxt       = state_r;
    rd_addr_nxt     = rd_addr_r;
    issue_nxt       = issue_r;
    dv_nxt          = 1'b0;
    sum_nxt         = sum_r;
    div_nxt         = div_r;
    last_nxt        = last_r;
    dq_nxt          = dq_r;
    rem_nxt         = rem_r;
    neg_nxt         = neg_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_average_nxt = out_average_r;
    out_last_nxt    = out_last_r;
    job_pop         = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          job_pop     = 1'b1;
          rd_addr_nxt = job.start;
          issue_nxt   = job.count;
          div_nxt     = job.count;
          last_nxt    = job.last;
          sum_nxt     = '0;
          state_nxt   = B_READ;
        end
      end
      B_READ: begin
        if (issue_r != '0) begin
          rd_addr_nxt = (rd_addr_r == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_addr_r + 1'b1;
          issue_nxt   = issue_r - 1'b1;
          dv_nxt      = 1'b1;
        end
        if (dv_r) begin
          sum_nxt = sum_r + SUM_W'(rd_data_r);
        end
        if ((issue_r == '0) && !dv_r) begin
          neg_nxt   = sum_r[SUM_W-1];
          dq_nxt    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
          rem_nxt   = '0;
          step_nxt  = STEP_W'(SUM_W);
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dq_nxt   = {dq_r[SUM_W-2:0], ge};
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = quot[SAMPLE_BITS-1:0];
          out_last_nxt    = last_r;
          state_nxt       = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r     <= rd_addr_nxt;
    issue_r       <= issue_nxt;
    sum_r         <= sum_nxt;
    div_r         <= div_nxt;
    last_r        <= last_nxt;
    dq_r          <= dq_nxt;
    rem_r         <= rem_nxt;
    neg_r         <= neg_nxt;
    step_r        <= step_nxt;
    out_average_r <= out_average_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule

// ===== rtl/centered_moving_average.sv =====
// Top level of the centered moving average: configuration register, front,
// job queue and back. Depends on cma_pkg, cma_front, cma_queue, cma_back.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, in_sample, in_frame_end sink
//   result    out_valid/out_ready, out_average, out_last source
//   config    psel/penable/pwrite/paddr/pwdata/prdata    APB slave, pready tied high
//
// Each result pops its job, sums its window from the ring memory (one read port, one sample a
// cycle), runs SUM_W (22 by default) divider steps and loads the output register. A sample is
// taken only when the job queue is empty and the back end is not reading the ring. Synchronous
// active-low reset; no clearing pass needed.
// A stalled output holds its result while the back end works on the next job.
module centered_moving_average #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  logic                               in_frame_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_average,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cma_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cma_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cma_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import cma_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_HALF + 1;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int JOB_W      = IDX_W + CNT_W + 1;
  localparam int WR_W       = 1 + IDX_W + SAMPLE_BITS;
  localparam int QDEPTH     = 4;
  localparam int HW_CAP     = (MAX_HALF < 31) ? MAX_HALF : 31;

  logic [HW_W-1:0]  half_window_r, half_window_nxt;
  logic             reg_hit;
  logic             q_empty, q_full, job_push, job_pop, back_busy;
  logic [JOB_W-1:0] push_data, pop_data;
  logic [WR_W-1:0]  ring_wr;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_HALF_WINDOW);
  assign prdata  = reg_hit ? APB_DATA_W'(half_window_r) : '0;

  always_comb begin
    half_window_nxt = half_window_r;
    if (psel && penable && pwrite && reg_hit) begin
      if (int'(pwdata[HW_W-1:0]) > HW_CAP) begin
        half_window_nxt = HW_W'(HW_CAP);
      end else begin
        half_window_nxt = pwdata[HW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r <= HW_RESET;
    end else begin
      half_window_r <= half_window_nxt;
    end
  end

  cma_front #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_frame_end(in_frame_end),
    .half_window (half_window_r),
    .q_empty     (q_empty),
    .q_full      (q_full),
    .back_busy   (back_busy),
    .job_push    (job_push),
    .job_data    (push_data),
    .ring_wr     (ring_wr)
  );

  cma_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(push_data),
    .pop      (job_pop),
    .pop_data (pop_data),
    .empty    (q_empty),
    .full     (q_full)
  );

  cma_back #(
    .MAX_HALF   (MAX_HALF),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ring_wr    (ring_wr),
    .q_empty    (q_empty),
    .job_pop    (job_pop),
    .job_data   (pop_data),
    .busy       (back_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_average(out_average),
    .out_last   (out_last)
  );

endmodule

// ===== rtl/cma_checker.sv =====
// Port-level checks for centered_moving_average, attached by bind.
// Depends on cma_pkg and the top level's port list.
module cma_checker #(
  parameter int MAX_HALF    = cma_pkg::MAX_HALF_DEF,
  parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_BITS-1:0]  out_average,
  input logic                           out_last,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [cma_pkg::APB_ADDR_W-1:0] paddr,
  input logic [cma_pkg::APB_DATA_W-1:0] pwdata,
  input logic [cma_pkg::APB_DATA_W-1:0] prdata,
  input logic                           pready
);
  import cma_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_last))
    else $error("result changed while stalled");

  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while previous one still being scheduled");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1:2] == REG_HALF_WINDOW) &&
    (int'(pwdata[HW_W-1:0]) <= MAX_HALF)
    |=> (paddr[APB_ADDR_W-1:2] != REG_HALF_WINDOW) ||
        (prdata == APB_DATA_W'($past(pwdata[HW_W-1:0]))))
    else $error("half_window readback mismatch");

endmodule

bind centered_moving_average cma_checker #(
  .MAX_HALF   (MAX_HALF),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_cma_checker (.*);
